// File: rtl/core/rss_pkg.sv
`default_nettype none

package rss_pkg;

   localparam int KEY_W = 32;
   localparam int TAG_W = 16;
   localparam int REC_W = KEY_W + TAG_W;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   // source of the data written into the record memory
   typedef enum logic [1:0] {
      WSEL_INPUT,
      WSEL_POS,
      WSEL_BEST
   } wsel_type;

   // read-return qualifiers from sequencer to minimum tracker
   typedef struct packed {
      logic vld;   // memory read data valid this cycle
      logic init;  // read data is the record at the current position
   } sel_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/rss_ram.sv
`default_nettype none

module rss_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// File: rtl/core/rss_best.sv
`default_nettype none

module rss_best #(
   parameter int MAX_RECORDS = 64
) (
   input  wire logic                             clock,
   input  wire rss_pkg::sel_ctl_type             sel_ctl,
   input  wire logic [$clog2(MAX_RECORDS)-1:0]   rd_idx,
   input  wire logic [rss_pkg::REC_W-1:0]        rd_data,
   output logic      [$clog2(MAX_RECORDS)-1:0]   best_idx,
   output logic      [rss_pkg::REC_W-1:0]        best_rec,
   output logic      [rss_pkg::REC_W-1:0]        pos_rec
);

   import rss_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);

   logic [AW-1:0]    best_idx_ff, best_idx_in;
   logic [REC_W-1:0] best_rec_ff, best_rec_in;
   logic [REC_W-1:0] pos_rec_ff, pos_rec_in;
   logic             key_lt;

   // strict signed compare keeps the first of equal minima
   assign key_lt = $signed(rd_data[REC_W-1:TAG_W]) < $signed(best_rec_ff[REC_W-1:TAG_W]);

   always_comb begin
      best_idx_in = best_idx_ff;
      best_rec_in = best_rec_ff;
      pos_rec_in  = pos_rec_ff;
      if (sel_ctl.vld) begin
         if (sel_ctl.init) begin
            best_idx_in = rd_idx;
            best_rec_in = rd_data;
            pos_rec_in  = rd_data;
         end else if (key_lt) begin
            best_idx_in = rd_idx;
            best_rec_in = rd_data;
         end
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      pos_rec_ff  <= pos_rec_in;
   end

   assign best_idx = best_idx_ff;
   assign best_rec = best_rec_ff;
   assign pos_rec  = pos_rec_ff;

endmodule

`default_nettype wire

// File: rtl/core/rss_seq.sv
`default_nettype none

module rss_seq #(
   parameter int MAX_RECORDS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             req_last_record,
   input  wire logic [$clog2(MAX_RECORDS)-1:0]   best_idx,
   output logic                                  busy,
   output logic                                  mem_we,
   output logic      [$clog2(MAX_RECORDS)-1:0]   mem_waddr,
   output rss_pkg::wsel_type                     mem_wsel,
   output logic      [$clog2(MAX_RECORDS)-1:0]   mem_raddr,
   output rss_pkg::sel_ctl_type                  sel_ctl,
   output logic      [$clog2(MAX_RECORDS)-1:0]   rd_idx,
   output logic                                  rsp_valid,
   output logic                                  rsp_end_of_run,
   output logic                                  rsp_overflow
);

   import rss_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic        rd_vld_ff, rd_vld_in;
   logic        rd_init_ff, rd_init_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic        rsp_vld_ff, rsp_vld_in;
   logic        eor_ff, eor_in;

   logic          accept;
   logic          has_room;
   logic [CW-1:0] count_new;
   logic [CW-1:0] last_idx;
   logic          scan_at_end;
   logic [CW-1:0] pos_plus2;

   assign accept      = start && (state_ff == ST_LOAD);
   assign has_room    = count_ff < CW'(MAX_RECORDS);
   assign count_new   = has_room ? count_ff + CW'(1) : count_ff;
   assign last_idx    = count_ff - CW'(1);
   assign scan_at_end = CW'(scan_ff) == last_idx;
   assign pos_plus2   = CW'(pos_ff) + CW'(2);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_record) begin
               state_in = (count_new >= CW'(2)) ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (scan_at_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_SWAP_A;
         ST_SWAP_A: state_in = ST_SWAP_B;
         ST_SWAP_B: state_in = (pos_plus2 < count_ff) ? ST_SCAN : ST_EMIT;
         ST_EMIT: begin
            if (scan_at_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH:  state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   // outputs and datapath register updates
   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      pos_in     = pos_ff;
      scan_in    = scan_ff;
      rd_vld_in  = 1'b0;
      rd_init_in = 1'b0;
      rd_idx_in  = scan_ff;
      rsp_vld_in = 1'b0;
      eor_in     = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = count_ff[AW-1:0];
      mem_wsel   = WSEL_INPUT;
      mem_raddr  = scan_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               mem_we   = has_room;
               count_in = count_new;
               if (!has_room) begin
                  ovf_in = 1'b1;
               end
               pos_in  = '0;
               scan_in = '0;
            end
         end
         ST_SCAN: begin
            // stream reads from the current position to the end
            rd_vld_in  = 1'b1;
            rd_init_in = scan_ff == pos_ff;
            scan_in    = scan_ff + AW'(1);
         end
         ST_DRAIN: begin
         end
         ST_SWAP_A: begin
            mem_we    = best_idx != pos_ff;
            mem_waddr = best_idx;
            mem_wsel  = WSEL_POS;
         end
         ST_SWAP_B: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wsel  = WSEL_BEST;
            pos_in    = pos_ff + AW'(1);
            scan_in   = (pos_plus2 < count_ff) ? pos_ff + AW'(1) : '0;
         end
         ST_EMIT: begin
            rsp_vld_in = 1'b1;
            eor_in     = scan_at_end;
            scan_in    = scan_ff + AW'(1);
         end
         ST_FLUSH: begin
            // last item is on the result ports this cycle
            count_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // indices and flags that need no reset
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      scan_ff    <= scan_in;
      rd_init_ff <= rd_init_in;
      rd_idx_ff  <= rd_idx_in;
      eor_ff     <= eor_in;
   end

   assign busy           = state_ff != ST_LOAD;
   assign sel_ctl.vld    = rd_vld_ff;
   assign sel_ctl.init   = rd_init_ff;
   assign rd_idx         = rd_idx_ff;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_end_of_run = eor_ff;
   assign rsp_overflow   = ovf_ff;

   // fill count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS))
      else $error("record count above capacity");

   // results only follow an emit read
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (state_ff == ST_EMIT || state_ff == ST_FLUSH))
      else $error("result strobe outside emit phase");

   // a closing item always locks the input
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_record) |=> busy)
      else $error("block idle after closing item");

   // scan never runs behind the position being filled
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff >= pos_ff))
      else $error("scan index behind position");

endmodule

`default_nettype wire

// File: rtl/core/record_selection_sort_by_id_core.sv
`default_nettype none

// Loading: start is taken whenever busy is low, so items may follow back to back.
// Closing item with n stored records: for n of two or more, the sort walks each position
// in turn (one memory read per remaining record, a drain state and two swap states, the
// first writing only when the minimum lies elsewhere), then all n records are emitted
// in order, one result per cycle. The receiver cannot stall. Synchronous reset clears
// the sequencer, fill count and overflow flag; the record memory is not cleared.
module record_selection_sort_by_id_core #(
   parameter int MAX_RECORDS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rss_pkg::KEY_W-1:0]     req_sort_key,
   input  wire logic [rss_pkg::TAG_W-1:0]     req_record_tag,
   input  wire logic                          req_last_record,
   output logic                               rsp_valid,
   output logic      [rss_pkg::KEY_W-1:0]     rsp_sorted_key,
   output logic      [rss_pkg::TAG_W-1:0]     rsp_sorted_tag,
   output logic                               rsp_end_of_run,
   output logic                               rsp_overflow
);

   import rss_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   wsel_type         mem_wsel;
   logic [AW-1:0]    mem_raddr;
   logic [REC_W-1:0] mem_wdata;
   logic [REC_W-1:0] mem_rdata;
   sel_ctl_type      sel_ctl;
   logic [AW-1:0]    rd_idx;
   logic [AW-1:0]    best_idx;
   logic [REC_W-1:0] best_rec;
   logic [REC_W-1:0] pos_rec;

   rss_seq #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last_record(req_last_record),
      .best_idx       (best_idx),
      .busy           (busy),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wsel       (mem_wsel),
      .mem_raddr      (mem_raddr),
      .sel_ctl        (sel_ctl),
      .rd_idx         (rd_idx),
      .rsp_valid      (rsp_valid),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_overflow   (rsp_overflow)
   );

   rss_best #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_best (
      .clock   (clock),
      .sel_ctl (sel_ctl),
      .rd_idx  (rd_idx),
      .rd_data (mem_rdata),
      .best_idx(best_idx),
      .best_rec(best_rec),
      .pos_rec (pos_rec)
   );

   // write data: incoming record or one side of a swap
   always_comb begin
      unique case (mem_wsel)
         WSEL_INPUT: mem_wdata = {req_sort_key, req_record_tag};
         WSEL_POS:   mem_wdata = pos_rec;
         WSEL_BEST:  mem_wdata = best_rec;
         default:    mem_wdata = {req_sort_key, req_record_tag};
      endcase
   end

   rss_ram #(
      .WIDTH(REC_W),
      .DEPTH(MAX_RECORDS)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign rsp_sorted_key = mem_rdata[REC_W-1:TAG_W];
   assign rsp_sorted_tag = mem_rdata[TAG_W-1:0];

endmodule

`default_nettype wire

// File: tb/sv/record_selection_sort_by_id_core_test.sv
`timescale 1ns / 1ps

module record_selection_sort_by_id_core_test;
   import rss_pkg::*;

   localparam int SLOTS       = 64;
   localparam int ITEM_TARGET = 410;

   // one sorted record as it should leave the block
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             end_of_run;
      logic             overflow;
   } sorted_entry_type;

   // keeps a shadow of the record store and the queue of sorted records still owed
   class sorted_run_board;
      logic [KEY_W-1:0] key_slot [SLOTS];
      logic [TAG_W-1:0] tag_slot [SLOTS];
      int               fill;
      bit               dropped;
      sorted_entry_type sorted_due [$];
      int               errors;
      int               checked;
      int               sets_closed;
      int               overflow_sets;

      function new();
         fill          = 0;
         dropped       = 0;
         errors        = 0;
         checked       = 0;
         sets_closed   = 0;
         overflow_sets = 0;
      endfunction

      // an item was taken by the block
      function void note_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
         int               best;
         logic [KEY_W-1:0] k;
         logic [TAG_W-1:0] t;
         sorted_entry_type e;
         if (fill < SLOTS) begin
            key_slot[fill] = key;
            tag_slot[fill] = tag;
            fill++;
         end else begin
            dropped = 1'b1;
         end
         if (!last) return;
         // selection sort: first strictly smallest key wins each position
         for (int pos = 0; pos + 1 < fill; pos++) begin
            best = pos;
            for (int scan = pos + 1; scan < fill; scan++)
               if ($signed(key_slot[scan]) < $signed(key_slot[best])) best = scan;
            if (best != pos) begin
               k              = key_slot[pos];
               t              = tag_slot[pos];
               key_slot[pos]  = key_slot[best];
               tag_slot[pos]  = tag_slot[best];
               key_slot[best] = k;
               tag_slot[best] = t;
            end
         end
         for (int i = 0; i < fill; i++) begin
            e.key        = key_slot[i];
            e.tag        = tag_slot[i];
            e.end_of_run = (i + 1 == fill);
            e.overflow   = dropped;
            sorted_due.push_back(e);
         end
         sets_closed++;
         if (dropped) overflow_sets++;
         fill    = 0;
         dropped = 1'b0;
      endfunction

      // compare one emitted record against the oldest one owed
      function void check_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                 logic eor, logic ovf);
         sorted_entry_type want;
         if (sorted_due.size() == 0) begin
            $error("result with nothing owed: key %0d tag %0h", $signed(key), tag);
            errors++;
            return;
         end
         want = sorted_due.pop_front();
         checked++;
         if (key !== want.key) begin
            $error("sorted_key expected %0d got %0d", $signed(want.key), $signed(key));
            errors++;
         end
         if (tag !== want.tag) begin
            $error("sorted_tag expected %0h got %0h", want.tag, tag);
            errors++;
         end
         if (eor !== want.end_of_run) begin
            $error("end_of_run expected %0b got %0b", want.end_of_run, eor);
            errors++;
         end
         if (ovf !== want.overflow) begin
            $error("overflow expected %0b got %0b", want.overflow, ovf);
            errors++;
         end
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction
   endclass

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             start           = 1'b0;
   logic [KEY_W-1:0] req_sort_key    = '0;
   logic [TAG_W-1:0] req_record_tag  = '0;
   logic             req_last_record = 1'b0;
   wire              busy;
   wire              rsp_valid;
   wire [KEY_W-1:0]  rsp_sorted_key;
   wire [TAG_W-1:0]  rsp_sorted_tag;
   wire              rsp_end_of_run;
   wire              rsp_overflow;

   sorted_run_board board = new();
   int              items_sent = 0;

   record_selection_sort_by_id_core #(.MAX_RECORDS(SLOTS)) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sort_key    (req_sort_key),
      .req_record_tag  (req_record_tag),
      .req_last_record (req_last_record),
      .rsp_valid       (rsp_valid),
      .rsp_sorted_key  (rsp_sorted_key),
      .rsp_sorted_tag  (rsp_sorted_tag),
      .rsp_end_of_run  (rsp_end_of_run),
      .rsp_overflow    (rsp_overflow)
   );

   always #6 clock = ~clock;

   // result side: every strobe is a record, sampled at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_record(rsp_sorted_key, rsp_sorted_tag, rsp_end_of_run, rsp_overflow);
   end

   // present one item and hold it until the block takes it
   task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                              input logic last, input bit quick);
      int gap;
      gap = quick ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_sort_key    <= key;
      req_record_tag  <= tag;
      req_last_record <= last;
      do @(posedge clock); while (busy);
      board.note_record(key, tag, last);
      items_sent++;
   endtask

   // one whole set, last item closes it; some sets go back to back
   task automatic send_set(input logic [KEY_W-1:0] keys [$], input logic [TAG_W-1:0] tags [$]);
      bit quick;
      quick = ($urandom_range(0, 3) == 0);
      foreach (keys[i]) send_record(keys[i], tags[i], i == keys.size() - 1, quick);
   endtask

   // key flavors: full range, tight signed range for ties, extremes, small positives
   function automatic logic [KEY_W-1:0] draw_key(int mode);
      int pick;
      case (mode)
         1: return $urandom_range(0, 8) - 4;
         2: begin
            pick = $urandom_range(0, 4);
            case (pick)
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         3: return $urandom_range(0, 1000);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [KEY_W-1:0] keys [$];
      logic [TAG_W-1:0] tags [$];
      int n;
      int r;
      int set_mode;
      int set_no;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: single records at the key extremes
      keys = '{32'h7FFF_FFFF};              tags = '{16'hFFFF};  send_set(keys, tags);
      keys = '{32'h8000_0000};              tags = '{16'h0000};  send_set(keys, tags);
      // pair out of order, already sorted, fully reversed
      keys = '{5, -3};                      tags = '{16'h1111, 16'h2222};  send_set(keys, tags);
      keys = '{-2, 0, 7};                   tags = '{16'h0001, 16'h0002, 16'h0003};
      send_set(keys, tags);
      keys = '{40, 30, -20, -30};           tags = '{16'hA000, 16'hB000, 16'hC000, 16'hD000};
      send_set(keys, tags);
      // equal keys: swaps reorder the duplicates
      keys = '{3, 3, 1, 3, 1};              tags = '{16'h0001, 16'h0002, 16'h0003, 16'h0004,
                                                     16'h0005};
      send_set(keys, tags);
      // mix of extremes with repeats
      keys = '{32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1, 32'h8000_0000, 32'h7FFF_FFFF};
      tags = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234};
      send_set(keys, tags);

      // random sets: mostly short, a few full, a couple that overrun the store
      set_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (set_no == 2 || set_no == 11) begin
            n = SLOTS + $urandom_range(1, 6);
         end else if (set_no == 6) begin
            n = SLOTS;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 75)      n = $urandom_range(1, 8);
            else if (r < 95) n = $urandom_range(9, 24);
            else             n = $urandom_range(25, SLOTS);
         end
         set_mode = $urandom_range(0, 4);
         keys.delete();
         tags.delete();
         for (int i = 0; i < n; i++) begin
            keys.push_back(draw_key(set_mode == 4 ? $urandom_range(0, 3) : set_mode));
            tags.push_back(TAG_W'($urandom_range(0, 16'hFFFF)));
         end
         send_set(keys, tags);
         set_no++;
      end
      start <= 1'b0;

      // drain what is still owed, then a short quiet window
      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d items in %0d sets, %0d of them past capacity.",
               items_sent, board.sets_closed, board.overflow_sets);
      $display("Compared %0d sorted records field by field.", board.checked);
      if (board.errors == 0) begin
         $display("record_selection_sort_by_id_core verification clean");
      end else begin
         $display("record_selection_sort_by_id_core verification failed");
      end
      $finish;
   end

   // generous ceiling, far above the slowest legal run
   initial begin
      #3_000_000;
      $display("record_selection_sort_by_id_core verification failed");
      $finish;
   end

endmodule
